// ----- src/srr_pkg.sv -----
// shared types, constants and the modulo step of the selective-repeat receiver
package srr_pkg;

  localparam int SEQ_W    = 32;
  localparam int TAG_W    = 16;
  localparam int KIND_W   = 2;
  localparam int WSIZE_W  = 5;

  // remainder unit retires this many dividend bits per cycle
  localparam int MOD_BITS_PER_CYCLE = 2;
  localparam int MOD_CYCLES         = SEQ_W / MOD_BITS_PER_CYCLE;
  localparam int MOD_COUNT_W        = $clog2(MOD_CYCLES);

  localparam logic [KIND_W-1:0] KIND_DELIVER   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK       = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINAL_ACK = 2'd2;

  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 5'd16;

  typedef logic [SEQ_W-1:0]   seq_t;
  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [WSIZE_W-1:0] wsize_t;

  // one restoring remainder step: bring in one dividend bit, subtract if it fits
  function automatic wsize_t mod_step(input wsize_t rem, input logic din, input wsize_t w);
    logic [WSIZE_W:0] t;
    t = {rem, din};
    if (t >= {1'b0, w}) begin
      t = t - {1'b0, w};
    end
    return t[WSIZE_W-1:0];
  endfunction

endpackage

// ----- src/srr_packet_if.sv -----
// packet channel into the receiver
interface srr_packet_if;
  logic                valid;
  logic                ready;
  srr_pkg::seq_t       sequence_number;
  logic                is_last_packet;
  logic                checksum_ok;
  srr_pkg::tag_t       payload_tag;

  modport source (output valid, sequence_number, is_last_packet, checksum_ok, payload_tag,
                  input ready);
  modport sink   (input valid, sequence_number, is_last_packet, checksum_ok, payload_tag,
                  output ready);
endinterface

// ----- src/srr_result_if.sv -----
// result channel out of the receiver
interface srr_result_if;
  logic                valid;
  logic                ready;
  srr_pkg::kind_t      result_kind;
  srr_pkg::seq_t       result_sequence;
  srr_pkg::tag_t       result_payload;
  logic                last_of_run;

  modport source (output valid, result_kind, result_sequence, result_payload, last_of_run,
                  input ready);
  modport sink   (input valid, result_kind, result_sequence, result_payload, last_of_run,
                  output ready);
endinterface

// ----- src/selective_repeat_receiver_core.sv -----
// selective-repeat receive window: slot store, remainder unit, drain sequencer
//
//   channel   dir  handshake        word
//   packets   in   valid / ready    sequence_number, is_last_packet, checksum_ok, payload_tag
//   results   out  valid / ready    result_kind, result_sequence, result_payload, last_of_run
//   cfg       in   cfg_we           cfg_wdata = window_size
//
// steps: accept, window check, the shared remainder unit, slot write, ack;
// an in-order packet adds a read / deliver pair per word and one closing read
// before the ack; an old packet goes from the window check straight to the ack,
// one beyond the window back to idle, and a bad-checksum or post-final one is ignored at accept.
// reset (rst, synchronous) clears the arrival flags and control at once;
// a stalled result holds the sequencer in its deliver or ack step, but a packet
// can still be taken while the last word waits in the output register
module selective_repeat_receiver_core #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  srr_packet_if.sink            packets,
  srr_result_if.source          results,
  input  logic                  cfg_we,
  input  srr_pkg::wsize_t       cfg_wdata
);

  // window size register can name at most 31 slots, so no more are reachable
  localparam int WMAX  = (WINDOW_DEPTH < 31) ? WINDOW_DEPTH : 31;
  localparam int SLOTS = WMAX;
  localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [srr_pkg::WSIZE_W-1:0] WMAX_V = srr_pkg::WSIZE_W'(WMAX);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_MOD     = 3'd2;
  localparam logic [2:0] S_WRITE   = 3'd3;
  localparam logic [2:0] S_READ    = 3'd4;
  localparam logic [2:0] S_DELIVER = 3'd5;
  localparam logic [2:0] S_ACK     = 3'd6;

  logic [2:0]               state;
  srr_pkg::wsize_t          window_size;
  srr_pkg::seq_t            next_expected;
  logic [SLOTS-1:0]         arrived;
  logic                     final_known;
  srr_pkg::seq_t            final_sequence;
  logic                     finished;

  // working copy of the packet
  srr_pkg::seq_t            seq_r;
  srr_pkg::tag_t            tag_r;
  srr_pkg::seq_t            shift_r;
  srr_pkg::wsize_t          rem;
  logic [srr_pkg::MOD_COUNT_W-1:0] step_count;
  srr_pkg::wsize_t          slot;

  // slot payload store
  srr_pkg::tag_t            slot_payload [SLOTS];
  srr_pkg::tag_t            rd_data;

  // output register
  logic                     out_valid;
  srr_pkg::kind_t           out_kind;
  srr_pkg::seq_t            out_seq;
  srr_pkg::tag_t            out_payload;
  logic                     out_last;

  srr_pkg::wsize_t          w;
  srr_pkg::seq_t            diff;
  srr_pkg::seq_t            ack_num;
  srr_pkg::wsize_t          rem_next;
  srr_pkg::wsize_t          slot_inc;
  logic                     out_free;
  logic                     out_load;
  logic                     accept;

  // clamp window size to 1..built depth
  always_comb begin
    if (window_size == '0) begin
      w = srr_pkg::WSIZE_W'(1);
    end else if (window_size > WMAX_V) begin
      w = WMAX_V;
    end else begin
      w = window_size;
    end
  end

  assign diff     = seq_r - next_expected;
  assign ack_num  = next_expected - srr_pkg::SEQ_W'(1);
  assign rem_next = srr_pkg::mod_step(srr_pkg::mod_step(rem, shift_r[srr_pkg::SEQ_W-1], w),
                                      shift_r[srr_pkg::SEQ_W-2], w);
  // walk to the next slot, wrapping at the window size
  assign slot_inc = (slot + srr_pkg::WSIZE_W'(1) == w) ? '0 : slot + srr_pkg::WSIZE_W'(1);
  assign out_free = !out_valid || results.ready;
  // a new word goes into the output register this cycle
  assign out_load = out_free && ((state == S_DELIVER) || (state == S_ACK));
  assign accept   = packets.valid && packets.ready;

  assign packets.ready           = (state == S_IDLE);
  assign results.valid           = out_valid;
  assign results.result_kind     = out_kind;
  assign results.result_sequence = out_seq;
  assign results.result_payload  = out_payload;
  assign results.last_of_run     = out_last;

  // payload store: one write port, one registered read port at the current slot
  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      slot_payload[slot[IW-1:0]] <= tag_r;
    end
    rd_data <= slot_payload[slot[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      window_size    <= srr_pkg::WSIZE_RESET;
      next_expected  <= '0;
      arrived        <= '0;
      final_known    <= 1'b0;
      final_sequence <= '0;
      finished       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_size <= cfg_wdata;
      end
      if (out_valid && results.ready && !out_load) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept && !finished) begin
            // last flag is recorded even when the checksum failed
            if (packets.is_last_packet) begin
              final_known    <= 1'b1;
              final_sequence <= packets.sequence_number;
            end
            seq_r <= packets.sequence_number;
            tag_r <= packets.payload_tag;
            if (packets.checksum_ok) begin
              state <= S_CHECK;
            end
          end
        end

        S_CHECK: begin
          rem        <= '0;
          shift_r    <= seq_r;
          step_count <= '0;
          if (seq_r < next_expected) begin
            state <= S_ACK;         // old packet, ack only
          end else if (diff >= srr_pkg::SEQ_W'(w)) begin
            state <= S_IDLE;        // beyond the window
          end else begin
            state <= S_MOD;
          end
        end

        S_MOD: begin
          rem        <= rem_next;
          shift_r    <= shift_r << srr_pkg::MOD_BITS_PER_CYCLE;
          step_count <= step_count + srr_pkg::MOD_COUNT_W'(1);
          if (step_count == srr_pkg::MOD_COUNT_W'(srr_pkg::MOD_CYCLES - 1)) begin
            slot  <= rem_next;
            state <= S_WRITE;
          end
        end

        S_WRITE: begin
          arrived[slot[IW-1:0]] <= 1'b1;
          // in-order packet sits at slot next_expected mod w, which is this slot
          state <= (seq_r == next_expected) ? S_READ : S_ACK;
        end

        S_READ: begin
          state <= arrived[slot[IW-1:0]] ? S_DELIVER : S_ACK;
        end

        S_DELIVER: begin
          if (out_free) begin
            out_valid             <= 1'b1;
            out_kind              <= srr_pkg::KIND_DELIVER;
            out_seq               <= next_expected;
            out_payload           <= rd_data;
            out_last              <= 1'b0;
            arrived[slot[IW-1:0]] <= 1'b0;
            next_expected         <= next_expected + srr_pkg::SEQ_W'(1);
            slot                  <= slot_inc;
            state                 <= S_READ;
          end
        end

        S_ACK: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_seq     <= ack_num;
            out_payload <= '0;
            out_last    <= 1'b1;
            if (final_known && ack_num == final_sequence) begin
              out_kind <= srr_pkg::KIND_FINAL_ACK;
              finished <= 1'b1;
            end else begin
              out_kind <= srr_pkg::KIND_ACK;
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/selective_repeat_receiver_core_tb.sv -----
// testbench for the selective-repeat receive window: directed and random packets, checked word by word
module selective_repeat_receiver_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 16;
  // worst drain: accept, window check, remainder unit, slot write, 16 read / deliver pairs, the closing read, ack
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_LIMIT   = 50000;

  // one result word as the block should present it
  typedef struct {
    srr_pkg::kind_t kind;
    srr_pkg::seq_t  seqn;
    srr_pkg::tag_t  payload;
    logic           run_end;
  } result_word_t;

  logic            clk;
  logic            rst;
  logic            cfg_we;
  srr_pkg::wsize_t cfg_wdata;

  srr_packet_if pkt_if ();
  srr_result_if res_if ();

  selective_repeat_receiver_core #(
    .WINDOW_DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .packets  (pkt_if),
    .results  (res_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // words still owed by the block, oldest first
  result_word_t due_results[$];

  // own copy of the receive window state
  srr_pkg::wsize_t win_cfg;
  srr_pkg::seq_t   next_seq;
  logic            arrived [DEPTH];
  srr_pkg::tag_t   parked  [DEPTH];
  logic            final_seen;
  srr_pkg::seq_t   final_seq;
  logic            rx_finished;

  // bookkeeping
  int error_count;
  int cycle_count;
  int packets_sent;
  int deliveries_seen;
  int acks_seen;
  int settings_used;
  int last_yield;
  bit quiet;

  // ---------------------------------------------------------------------------
  // clock, cycle counter and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // a hung handshake ends the run here
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receive window behaviour, worked out per accepted packet
  // ---------------------------------------------------------------------------

  // a written size of 0 behaves as 1, anything above the built depth as the depth
  function automatic int unsigned active_window();
    int unsigned w;
    w = win_cfg;
    if (w < 1) w = 1;
    if (w > DEPTH) w = DEPTH;
    return w;
  endfunction

  task automatic window_receive(input srr_pkg::seq_t seqn, input logic is_last, input logic ok,
                                input srr_pkg::tag_t tag);
    int unsigned   w;
    int unsigned   slot;
    int unsigned   drained;
    srr_pkg::seq_t ack;
    // once the final ack is out nothing moves any more
    if (rx_finished) return;
    // the last flag is recorded before the checksum verdict is looked at
    if (is_last) begin
      final_seen = 1'b1;
      final_seq  = seqn;
    end
    if (!ok) return;
    // old packets skip straight to the cumulative ack
    if (seqn >= next_seq) begin
      w = active_window();
      // window test without wrap-around
      if (srr_pkg::seq_t'(seqn - next_seq) >= w) return;
      slot         = seqn % w;
      parked[slot] = tag;
      arrived[slot] = 1'b1;
      if (seqn == next_seq) begin
        // in-order packet: hand out the run of arrived slots
        drained = 0;
        slot    = next_seq % w;
        while (arrived[slot] && drained < DEPTH) begin
          due_results.push_back(result_word_t'{srr_pkg::KIND_DELIVER, next_seq, parked[slot],
                                               1'b0});
          arrived[slot] = 1'b0;
          next_seq      = next_seq + 1;
          drained++;
          slot = next_seq % w;
        end
      end
    end
    // cumulative ack for next - 1, wrapping at 2^32
    ack = next_seq - 1;
    if (final_seen && ack == final_seq) begin
      due_results.push_back(result_word_t'{srr_pkg::KIND_FINAL_ACK, ack, srr_pkg::tag_t'(0),
                                           1'b1});
      rx_finished = 1'b1;
    end else begin
      due_results.push_back(result_word_t'{srr_pkg::KIND_ACK, ack, srr_pkg::tag_t'(0), 1'b1});
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure and the word checker
  // ---------------------------------------------------------------------------

  // ready comes in runs, with stall bursts unless quiet
  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // each word taken at the edge is compared with the oldest one owed
  always @(posedge clk) begin : check_word
    result_word_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (due_results.size() == 0) begin
        error_count++;
        $error("unexpected result word: kind %0d sequence %0h payload %0h",
               res_if.result_kind, res_if.result_sequence, res_if.result_payload);
      end else begin
        want = due_results.pop_front();
        if (want.kind == srr_pkg::KIND_DELIVER) deliveries_seen++;
        else acks_seen++;
        if (res_if.result_kind !== want.kind) begin
          error_count++;
          $error("result_kind: expected %0d, got %0d", want.kind, res_if.result_kind);
        end
        if (res_if.result_sequence !== want.seqn) begin
          error_count++;
          $error("result_sequence: expected %0h, got %0h", want.seqn, res_if.result_sequence);
        end
        if (res_if.result_payload !== want.payload) begin
          error_count++;
          $error("result_payload: expected %0h, got %0h", want.payload, res_if.result_payload);
        end
        if (res_if.last_of_run !== want.run_end) begin
          error_count++;
          $error("last_of_run: expected %0b, got %0b", want.run_end, res_if.last_of_run);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // packet side
  // ---------------------------------------------------------------------------

  // offer one packet, possibly after an idle burst, and hold it until taken;
  // valid is left high on return so back-to-back packets need no gap
  task automatic send_packet(input srr_pkg::seq_t seqn, input logic is_last, input logic ok,
                             input srr_pkg::tag_t tag);
    int owed_before;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      pkt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    pkt_if.valid           <= 1'b1;
    pkt_if.sequence_number <= seqn;
    pkt_if.is_last_packet  <= is_last;
    pkt_if.checksum_ok     <= ok;
    pkt_if.payload_tag     <= tag;
    @(posedge clk);
    while (!pkt_if.ready) @(posedge clk);
    owed_before = due_results.size();
    window_receive(seqn, is_last, ok, tag);
    last_yield = due_results.size() - owed_before;
    packets_sent++;
  endtask

  // stop offering, let every owed word out, then give packets that owe nothing time to clear
  task automatic settle();
    pkt_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only ever called with the block idle
  task automatic write_window(input srr_pkg::wsize_t value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    win_cfg = value;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // fill slots 15 down to 1 out of order, overwrite one, then the missing head
  // releases the whole window: 16 deliveries and the ack in one run
  task automatic test_full_window_drain();
    srr_pkg::tag_t tags [DEPTH];
    for (int i = 0; i < DEPTH; i++) tags[i] = srr_pkg::tag_t'($urandom);
    tags[15] = 16'hFFFF;
    tags[14] = 16'h0000;
    tags[13] = 16'h00AA;
    tags[12] = 16'hAAAA;
    tags[11] = 16'h5500;
    // each of these acks 2^32 - 1, the wrapped value of next - 1
    for (int s = DEPTH - 1; s >= 1; s--) begin
      send_packet(srr_pkg::seq_t'(s), 1'b0, 1'b1, tags[s]);
    end
    // duplicate in the window replaces the parked payload
    tags[7] = ~tags[7];
    send_packet(srr_pkg::seq_t'(7), 1'b0, 1'b1, tags[7]);
    send_packet(srr_pkg::seq_t'(0), 1'b0, 1'b1, tags[0]);
  endtask

  // bad checksum on the expected packet gives nothing; a packet far past the
  // window gives nothing but still records its last flag
  task automatic test_rejected_packets();
    send_packet(next_seq, 1'b0, 1'b0, 16'hFFFF);
    send_packet(32'hFFFF_FFFF, 1'b1, 1'b1, 16'h5500);
  endtask

  // old packet carrying the last flag: ack only, and the flag overwrites the
  // recorded final sequence without matching the ack
  task automatic test_old_packet();
    send_packet(srr_pkg::seq_t'(3), 1'b1, 1'b1, 16'hAAAA);
  endtask

  // size 0 behaves as 1, 31 as the full depth; shrinking the window mid-transfer
  // leaves a parked flag behind in a slot no longer in use
  task automatic test_window_extremes();
    settle();
    write_window(5'd0);
    send_packet(next_seq, 1'b0, 1'b1, 16'h00AA);
    send_packet(next_seq + 1, 1'b0, 1'b1, 16'h0F0F);
    settle();
    write_window(5'd31);
    send_packet(next_seq + 3, 1'b0, 1'b1, 16'hC3C3);
    settle();
    write_window(5'd3);
    send_packet(next_seq, 1'b0, 1'b1, 16'h3C3C);
  endtask

  // ---------------------------------------------------------------------------
  // random traffic: mostly packets in the window with random order and content,
  // plus old, far-off and corrupted ones; phase length counts useful packets
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic(input srr_pkg::wsize_t size, input int useful_target);
    srr_pkg::seq_t seqn;
    srr_pkg::seq_t from_ack;
    logic          is_last;
    logic          ok;
    srr_pkg::tag_t tag;
    int unsigned   w;
    int unsigned   pick;
    int            useful;
    settle();
    write_window(size);
    useful = 0;
    while (useful < useful_target) begin
      w    = active_window();
      pick = $urandom_range(0, 99);
      ok   = ($urandom_range(0, 19) != 0);
      tag  = srr_pkg::tag_t'($urandom);
      if (pick < 15) begin
        seqn = next_seq;
      end else if (pick < 65) begin
        seqn = next_seq + $urandom_range(0, w - 1);
      end else if (pick < 75) begin
        if (next_seq != 0) seqn = $urandom_range(0, next_seq - 1);
        else seqn = next_seq;
      end else if (pick < 85) begin
        if ($urandom_range(0, 1) == 0) seqn = next_seq + w + $urandom_range(0, 40);
        else seqn = srr_pkg::seq_t'($urandom);
      end else begin
        // broken copy of a packet that would have fitted
        seqn = next_seq + $urandom_range(0, w - 1);
        ok   = 1'b0;
      end
      // last flags only where the ack can never catch up with them during the run,
      // otherwise the transfer would end early
      is_last  = ($urandom_range(0, 19) == 0);
      from_ack = seqn - (next_seq - 1);
      if (is_last && from_ack < 32'h0010_0000) is_last = 1'b0;
      send_packet(seqn, is_last, ok, tag);
      if (last_yield != 0) useful++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // end of transfer
  // ---------------------------------------------------------------------------

  // the expected packet marked last, then an old copy of next - 1 marked last,
  // which must produce the final ack if the first did not
  task automatic test_final_ack();
    send_packet(next_seq, 1'b1, 1'b1, srr_pkg::tag_t'($urandom));
    send_packet(next_seq - 1, 1'b1, 1'b1, srr_pkg::tag_t'($urandom));
  endtask

  // after the final ack every packet is taken and ignored
  task automatic test_input_after_final();
    send_packet(next_seq, 1'b0, 1'b1, 16'hFFFF);
    send_packet(srr_pkg::seq_t'(0), 1'b1, 1'b1, 16'h0000);
    send_packet(next_seq + 1, 1'b0, 1'b0, 16'h5500);
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    pkt_if.valid           <= 1'b0;
    pkt_if.sequence_number <= '0;
    pkt_if.is_last_packet  <= 1'b0;
    pkt_if.checksum_ok     <= 1'b0;
    pkt_if.payload_tag     <= '0;
    cfg_we                 <= 1'b0;
    cfg_wdata              <= '0;
    rst                    <= 1'b1;

    // window state after reset
    win_cfg     = srr_pkg::WSIZE_RESET;
    next_seq    = '0;
    final_seen  = 1'b0;
    final_seq   = '0;
    rx_finished = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      arrived[i] = 1'b0;
      parked[i]  = '0;
    end
    error_count     = 0;
    packets_sent    = 0;
    deliveries_seen = 0;
    acks_seen       = 0;
    settings_used   = 1;
    quiet           = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_full_window_drain();
    test_rejected_packets();
    test_old_packet();
    test_window_extremes();

    test_random_traffic(5'd16, 43);
    test_random_traffic(5'd1, 43);
    test_random_traffic(5'd31, 43);
    test_random_traffic(5'd0, 43);
    test_random_traffic(5'd5, 43);
    test_random_traffic(5'd9, 43);
    // closing stretch runs flat out on both sides
    quiet = 1'b1;
    test_random_traffic(5'd16, 43);

    test_final_ack();
    test_input_after_final();

    // wait for the owed words, bounded, then for anything stray
    pkt_if.valid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && due_results.size() != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_results.size() != 0) begin
      error_count += due_results.size();
      $error("%0d expected result words never arrived", due_results.size());
    end

    $display("run covered %0d packets over %0d window settings, %0d deliveries, %0d acks",
             packets_sent, settings_used, deliveries_seen, acks_seen);
    $display("transfer ended with a final ack: %0b, later packets ignored", rx_finished);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
